// File: sv/pls_pkg.sv
// Package for positional_list_store: list capacity, derived widths, command codes,
// item structs and the per-cell control struct.
// No dependencies.
package pls_pkg;

    localparam int CAPACITY = 32;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 6;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } s_item_t;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         list_length;
    } m_item_t;

    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_down;
    } cell_ctl_t;

endpackage

// File: sv/pls_cell.sv
// One list slot: a word register that holds, loads a new value, or takes
// the word of its lower or upper neighbor. Depends on pls_pkg.
module pls_cell import pls_pkg::*; (
    input  logic                     aclk,
    input  cell_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] load_data,
    input  logic signed [DATA_W-1:0] lower_data,
    input  logic signed [DATA_W-1:0] upper_data,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.load) begin
            data_next = load_data;
        end else if (ctl.shift_up) begin
            data_next = lower_data;
        end else if (ctl.shift_down) begin
            data_next = upper_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: sv/pls_chain.sv
// Row of CAPACITY list cells wired to their neighbors, plus the read select.
// Depends on pls_pkg and pls_cell.
module pls_chain import pls_pkg::*; (
    input  logic                     aclk,
    input  cell_ctl_t                ctl [CAPACITY],
    input  logic signed [DATA_W-1:0] load_data,
    input  logic [IDX_W-1:0]         rd_idx,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [DATA_W-1:0] lower_w;
        logic signed [DATA_W-1:0] upper_w;

        if (k == 0) begin : g_first
            assign lower_w = '0;
        end else begin : g_lower
            assign lower_w = cell_data[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign upper_w = '0;
        end else begin : g_upper
            assign upper_w = cell_data[k+1];
        end

        pls_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl[k]),
            .load_data  (load_data),
            .lower_data (lower_w),
            .upper_data (upper_w),
            .data       (cell_data[k])
        );
    end

    assign rd_data = cell_data[rd_idx];

endmodule

// File: sv/positional_list_store.sv
// Top level of positional_list_store: command decode, length register,
// per-cell shift controls and result register. Depends on pls_pkg, pls_chain.
//
//   port group        dir  handshake          payload
//   s_*  commands     in   s_valid / s_ready  s_item  (cmd, position, value)
//   m_*  results      out  m_valid / m_ready  m_item  (status, read_value, list_length)
//
// One item per cycle unless m_ready stalls the result register: a command is
// decoded, the cell row shifts or loads, and the result is registered in the same cycle.
// The single result register sets the rate; s_ready is high whenever it is
// empty or being drained. Reset clears the length and the result valid;
// cell contents are left as they are and are only read below the length.
module positional_list_store import pls_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  s_item_t s_item,
    output logic    m_valid,
    input  logic    m_ready,
    output m_item_t m_item
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    m_item_t          m_item_reg;
    m_item_t          m_item_next;

    logic             accept;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] idx_ext;
    logic             pos_nonzero;
    logic             pos_in_list;
    logic             rd_ok;
    logic             ins_ok;
    logic             del_ok;
    cell_ctl_t        ctl [CAPACITY];
    logic signed [DATA_W-1:0] rd_data;

    assign accept      = s_valid && s_ready;
    assign s_ready     = !m_valid_reg || m_ready;

    assign pos_ext     = CMP_W'(s_item.position);
    assign cnt_ext     = CMP_W'(count_reg);
    assign idx_ext     = pos_ext - CMP_W'(1);
    assign pos_nonzero = (s_item.position != '0);
    assign pos_in_list = pos_nonzero && (pos_ext <= cnt_ext);

    assign rd_ok  = (s_item.cmd == CMD_READ) && pos_in_list;
    assign del_ok = (s_item.cmd == CMD_DELETE) && pos_in_list;
    assign ins_ok = (s_item.cmd == CMD_INSERT) && pos_nonzero
                    && (cnt_ext < CMP_W'(CAPACITY))
                    && (pos_ext <= cnt_ext + CMP_W'(1));

    for (genvar k = 0; k < CAPACITY; k++) begin : g_ctl
        always_comb begin
            ctl[k].load       = accept && ins_ok && (CMP_W'(k) == idx_ext);
            ctl[k].shift_up   = accept && ins_ok && (CMP_W'(k) > idx_ext);
            ctl[k].shift_down = accept && del_ok && (CMP_W'(k) >= idx_ext);
        end
    end

    pls_chain u_chain (
        .aclk      (aclk),
        .ctl       (ctl),
        .load_data (s_item.value),
        .rd_idx    (idx_ext[IDX_W-1:0]),
        .rd_data   (rd_data)
    );

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            if (ins_ok) begin
                count_next = count_reg + CNT_W'(1);
            end else if (del_ok) begin
                count_next = count_reg - CNT_W'(1);
            end
            m_valid_next            = 1'b1;
            m_item_next.status      = (rd_ok || ins_ok || del_ok) ? STATUS_OK : STATUS_ERR;
            m_item_next.read_value  = (rd_ok || del_ok) ? rd_data : '0;
            m_item_next.list_length = LEN_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("list length above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ins_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("successful insert did not grow the list");

    a_error_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !(rd_ok || ins_ok || del_ok)) |=>
            ($stable(count_reg) && m_item.status == STATUS_ERR && m_item.read_value == '0))
        else $error("failed command changed the list or returned data");

    a_length_match: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_item.list_length == LEN_W'(count_reg)))
        else $error("reported length differs from stored length");

endmodule

// File: sim/tb_positional_list_store.sv
// Self-checking testbench for positional_list_store: directed and random list commands
// with random source gaps and sink stalls; results are checked against an in-bench list model.
// Depends on pls_pkg and positional_list_store.
module tb_positional_list_store import pls_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         PHASE_ITEMS  = 100;
    localparam int         PHASE_COUNT  = 19;
    localparam int         REPORT_LIMIT = 10;

    typedef enum int {MIX_GROW, MIX_MIXED, MIX_SHRINK} mix_t;

    class list_tracker_t;
        logic signed [DATA_W-1:0] words [CAPACITY];
        int      length;
        m_item_t due_results [$];
        int      commands_seen;
        int      results_seen;
        int      error_results;
        int      full_refusals;
        int      peak_length;
        int      mismatches;

        function new();
            length        = 0;
            commands_seen = 0;
            results_seen  = 0;
            error_results = 0;
            full_refusals = 0;
            peak_length   = 0;
            mismatches    = 0;
        endfunction

        function void note_command(s_item_t c);
            m_item_t want;
            int      p;
            int      k;
            p = int'(c.position);
            want.status     = STATUS_ERR;
            want.read_value = '0;
            case (c.cmd)
                CMD_READ: begin
                    if (p >= 1 && p <= length) begin
                        want.status     = STATUS_OK;
                        want.read_value = words[p-1];
                    end
                end
                CMD_INSERT: begin
                    if (length < CAPACITY && p >= 1 && p <= length + 1) begin
                        for (k = length; k > p - 1; k--)
                            words[k] = words[k-1];
                        words[p-1] = c.value;
                        length++;
                        want.status = STATUS_OK;
                    end else if (length == CAPACITY) begin
                        full_refusals++;
                    end
                end
                CMD_DELETE: begin
                    if (p >= 1 && p <= length) begin
                        want.read_value = words[p-1];
                        for (k = p; k < length; k++)
                            words[k-1] = words[k];
                        length--;
                        want.status = STATUS_OK;
                    end
                end
                default: begin
                end
            endcase
            want.list_length = LEN_W'(length);
            if (want.status == STATUS_ERR)
                error_results++;
            if (length > peak_length)
                peak_length = length;
            commands_seen++;
            due_results.push_back(want);
        endfunction

        function void check_result(m_item_t got);
            m_item_t want;
            results_seen++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d value %0d length %0d",
                             got.status, got.read_value, got.list_length);
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.list_length !== want.list_length) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"mismatch on result %0d: expected status %0d value %0d ",
                              "length %0d, got status %0d value %0d length %0d"},
                             results_seen, want.status, want.read_value, want.list_length,
                             got.status, got.read_value, got.list_length);
            end
        endfunction
    endclass

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    s_item_t s_item  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    m_item_t m_item;

    list_tracker_t tracker = new();
    int            cycle_count = 0;
    int            stall_left  = 0;
    bit            idle_off    = 1'b0;

    positional_list_store uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, tracker.due_results.size());
            $display("tb_positional_list_store: FAIL");
            $finish;
        end
    end

    function automatic int idle_span();
        int r;
        if (idle_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // sink side: random stalls, no new ones start while idle_off is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (!idle_off && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left = idle_span();
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_item);
    end

    task automatic send_command(input s_item_t c);
        int gap;
        s_valid <= 1'b1;
        s_item  <= c;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        tracker.note_command(c);
        gap = idle_span();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_fields(input logic [1:0] cmd, input int pos, input logic [31:0] val);
        s_item_t c;
        c.cmd      = cmd;
        c.position = POS_W'(pos);
        c.value    = val;
        send_command(c);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.due_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic s_item_t make_command(input mix_t mix);
        s_item_t c;
        int      r;
        int      hi;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
                c.cmd = (r < 70) ? CMD_INSERT : (r < 82) ? CMD_READ :
                        (r < 96) ? CMD_DELETE : CMD_UNUSED;
            MIX_SHRINK:
                c.cmd = (r < 60) ? CMD_DELETE : (r < 78) ? CMD_INSERT :
                        (r < 95) ? CMD_READ : CMD_UNUSED;
            default:
                c.cmd = (r < 34) ? CMD_INSERT : (r < 66) ? CMD_DELETE :
                        (r < 96) ? CMD_READ : CMD_UNUSED;
        endcase
        hi = (c.cmd == CMD_INSERT) ? tracker.length + 1 : tracker.length;
        r = $urandom_range(0, 99);
        if (r < 8 || hi == 0) begin
            c.position = POS_W'($urandom_range(0, 63));
        end else if (r < 14) begin
            case ($urandom_range(0, 3))
                0:       c.position = '0;
                1:       c.position = POS_W'(hi);
                2:       c.position = POS_W'(hi + 1);
                default: c.position = '1;
            endcase
        end else begin
            c.position = POS_W'($urandom_range(1, hi));
        end
        r = $urandom_range(0, 99);
        if (r < 85)
            c.value = $urandom;
        else if (r < 90)
            c.value = 32'h7FFF_FFFF;
        else if (r < 95)
            c.value = 32'h8000_0000;
        else
            c.value = 32'(int'($urandom_range(0, 8)) - 4);
        return c;
    endfunction

    initial begin
        mix_t mix;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, bad positions, then a four-entry list built at front, end and middle
        send_fields(CMD_READ,   1,  32'h0000_0001);
        send_fields(CMD_DELETE, 1,  32'h0000_0002);
        send_fields(CMD_READ,   0,  32'h0000_0003);
        send_fields(CMD_INSERT, 0,  32'h1234_5678);
        send_fields(CMD_INSERT, 2,  32'h1234_5678);
        send_fields(CMD_INSERT, 1,  32'h7FFF_FFFF);
        send_fields(CMD_INSERT, 1,  32'h8000_0000);
        send_fields(CMD_INSERT, 3,  32'hFFFF_FFFF);
        send_fields(CMD_INSERT, 2,  32'h0000_0000);
        send_fields(CMD_READ,   1,  32'h0000_0000);
        send_fields(CMD_READ,   4,  32'hFFFF_FFFF);
        send_fields(CMD_READ,   5,  32'h0000_0000);
        send_fields(CMD_READ,   0,  32'h0000_0000);
        send_fields(CMD_READ,   63, 32'hFFFF_FFFF);
        send_fields(CMD_UNUSED, 1,  32'hAAAA_AAAA);
        send_fields(CMD_INSERT, 63, 32'h5555_5555);
        send_fields(CMD_DELETE, 5,  32'h0000_0000);
        send_fields(CMD_DELETE, 0,  32'h0000_0000);
        send_fields(CMD_DELETE, 2,  32'h0000_0000);
        send_fields(CMD_DELETE, 3,  32'h0000_0000);
        send_fields(CMD_DELETE, 1,  32'h0000_0000);
        send_fields(CMD_DELETE, 1,  32'h0000_0000);
        send_fields(CMD_READ,   1,  32'h0000_0000);
        wait_drained();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 4)
                0:       mix = MIX_GROW;
                2:       mix = MIX_SHRINK;
                default: mix = MIX_MIXED;
            endcase
            idle_off = (phase % 5 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_command(make_command(mix));
            if (phase % 3 == 2)
                wait_drained();
        end
        idle_off = 1'b0;

        wait_drained();
        repeat (8) @(posedge aclk);

        if (tracker.due_results.size() != 0) begin
            $display("%0d expected results never arrived", tracker.due_results.size());
            tracker.mismatches++;
        end
        $display("covered %0d commands and %0d results, %0d of them errors",
                 tracker.commands_seen, tracker.results_seen, tracker.error_results);
        $display("peak length %0d, %0d inserts refused on a full list, %0d mismatches",
                 tracker.peak_length, tracker.full_refusals, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("tb_positional_list_store: PASS");
        else
            $display("tb_positional_list_store: FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/pls_pkg.sv
sv/pls_cell.sv
sv/pls_chain.sv
sv/positional_list_store.sv
sim/tb_positional_list_store.sv
